// ===== rtl/core/tilt_balance_pid_controller_defines.svh =====
// Assertion macros for the tilt balance controller checker.
// Used by tbp_checker only; no dependencies.
`ifndef TILT_BALANCE_PID_CONTROLLER_DEFINES_SVH
`define TILT_BALANCE_PID_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tbp_pkg.sv =====
// Shared types and constants of the tilt balance controller.
// No dependencies; used by the divider, the top level and the checker.
package tbp_pkg;

    localparam logic signed [26:0] DEG180_Q16  = 27'sd11796480;
    localparam logic signed [23:0] INT_LIM_Q16 = 24'sd3276800;

    localparam int ATAN_LEN   = 24;
    localparam int ATAN_CNT_W = $clog2(ATAN_LEN);

    // atan(2^-i) in degrees, Q16.16
    localparam logic signed [26:0] ATAN_DEG_Q16 [0:ATAN_LEN-1] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

    localparam int DIV_W   = 32;
    localparam int DIV_D_W = 11;
    localparam int MUL_STEPS = 24;

    localparam logic [9:0] PWM_MAX_COUNT = 10'd1000;

    localparam logic [1:0] DIR_BRAKE = 2'd0;
    localparam logic [1:0] DIR_FWD   = 2'd1;
    localparam logic [1:0] DIR_BACK  = 2'd2;

    localparam logic [2:0] CFG_TARGET  = 3'd0;
    localparam logic [2:0] CFG_OFFSET  = 3'd1;
    localparam logic [2:0] CFG_GAIN_P  = 3'd2;
    localparam logic [2:0] CFG_GAIN_I  = 3'd3;
    localparam logic [2:0] CFG_GAIN_D  = 3'd4;
    localparam logic [2:0] CFG_CUTOFF  = 3'd5;
    localparam logic [2:0] CFG_CEILING = 3'd6;
    localparam logic [2:0] CFG_FLOOR   = 3'd7;

    typedef enum logic [1:0] {
        DIV_GYRO,
        DIV_ANGLE,
        DIV_INTEG,
        DIV_PWM
    } t_div_sel;

    typedef struct packed {
        logic     start;
        t_div_sel sel;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [DIV_D_W-1:0] div_const(input t_div_sel sel);
        logic [DIV_D_W-1:0] d;
        case (sel)
            DIV_GYRO:  d = 11'd625;
            DIV_ANGLE: d = 11'd100;
            DIV_INTEG: d = 11'd200;
            DIV_PWM:   d = 11'd255;
            default:   d = 11'd255;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/tbp_sdiv.sv =====
// Bit-serial restoring divider by one of a few small constants.
// One quotient bit per cycle; depends on tbp_pkg.
module tbp_sdiv
    import tbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [DIV_W-1:0] i_dividend,
    output t_div_stat        o_stat,
    output logic [DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_d;
    logic [DIV_W-1:0]   r_q;

    logic [DIV_D_W:0]   n_trial;
    logic               n_ge;
    logic [DIV_D_W:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_q[DIV_W-1]};
        n_ge    = n_trial >= {1'b0, r_d};
        n_diff  = n_trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_d    <= div_const(i_req.sel);
                r_q    <= i_dividend;
            end else if (r_busy) begin
                // dividend shifts out the top, quotient bits shift in at the bottom
                r_rem <= n_ge ? n_diff[DIV_D_W-1:0] : n_trial[DIV_D_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

// ===== rtl/core/tilt_balance_pid_controller.sv =====
// Tilt balance controller top level: CORDIC tilt, complementary filter, PID.
// Depends on tbp_pkg and tbp_sdiv.
//
// One item is one accelerometer/gyro sample; each yields one result. Items are
// handled one at a time; the time per item is set by the bit-serial divider
// (four divisions, two for a sample that trips the tilt cutoff) and the
// shift-add multiplier run once per gain. The input is stalled while an item
// is in work; a finished result waits in the output register and the next
// item can be taken meanwhile.
module tilt_balance_pid_controller
    import tbp_pkg::*;
#(
    parameter int ATAN_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [24:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_accel_y_word,
    input  logic signed [15:0] i_accel_z_word,
    input  logic signed [15:0] i_gyro_y_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_motor_direction,
    output logic [7:0]         o_drive_level,
    output logic [9:0]         o_pwm_compare,
    output logic               o_tilt_tripped,
    output logic signed [24:0] o_angle_estimate
);

    localparam int CORDIC_N = (ATAN_ITERATIONS > ATAN_LEN) ? ATAN_LEN : ATAN_ITERATIONS;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_CORD, S_TILT, S_DIVG, S_DIVA, S_ERR,
        S_DIVI, S_MUL, S_PID, S_DIVW, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_P, PH_I, PH_D
    } t_phase;

    // configuration
    logic signed [24:0] r_target, r_offset;
    logic [23:0]        r_gain_p, r_gain_i, r_gain_d, r_cutoff;
    logic [7:0]         r_ceiling, r_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_offset  <= '0;
            r_gain_p  <= 24'd1638400;
            r_gain_i  <= 24'd6554;
            r_gain_d  <= 24'd42598;
            r_cutoff  <= 24'd1310720;
            r_ceiling <= 8'd80;
            r_floor   <= 8'd25;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET:  r_target  <= $signed(i_cfg_data);
                CFG_OFFSET:  r_offset  <= $signed(i_cfg_data);
                CFG_GAIN_P:  r_gain_p  <= i_cfg_data[23:0];
                CFG_GAIN_I:  r_gain_i  <= i_cfg_data[23:0];
                CFG_GAIN_D:  r_gain_d  <= i_cfg_data[23:0];
                CFG_CUTOFF:  r_cutoff  <= i_cfg_data[23:0];
                CFG_CEILING: r_ceiling <= i_cfg_data[7:0];
                CFG_FLOOR:   r_floor   <= i_cfg_data[7:0];
                default:     r_floor   <= r_floor;
            endcase
        end
    end

    t_state             r_state;
    t_phase             r_phase;
    logic signed [11:0] r_ay, r_az;
    logic signed [15:0] r_gy;
    logic               r_zero;
    logic signed [31:0] r_x, r_y;
    logic signed [26:0] r_z;
    logic [ATAN_CNT_W-1:0] r_cnt;
    logic signed [26:0] r_tilt;
    logic               r_neg;
    logic signed [24:0] r_angle;
    logic signed [22:0] r_integ;
    logic signed [25:0] r_last;
    logic signed [25:0] r_err;
    logic signed [34:0] r_d200;
    logic signed [63:0] r_acc, r_mcand;
    logic [23:0]        r_mgain;
    logic [MUL_CNT_W-1:0] r_mcnt;
    logic [1:0]         r_dir;
    logic [7:0]         r_level;
    logic               r_trip;
    t_div_req           r_div_req;
    logic [DIV_W-1:0]   r_div_arg;

    logic               r_out_valid;
    logic [1:0]         r_o_dir;
    logic [7:0]         r_o_level;
    logic [9:0]         r_o_pwm;
    logic               r_o_trip;
    logic signed [24:0] r_o_angle;

    t_div_stat          w_div_stat;
    logic [DIV_W-1:0]   w_quot;

    tbp_sdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div_req),
        .i_dividend (r_div_arg),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    // datapath terms, one step per state
    logic signed [31:0] n_xs, n_ys, n_x0, n_y0;
    logic signed [26:0] n_zc;
    logic signed [26:0] n_gprod;
    logic [DIV_W-1:0]   n_gmag;
    logic signed [26:0] n_inc;
    logic signed [27:0] n_s;
    logic signed [35:0] n_num;
    logic [DIV_W-1:0]   n_nmag;
    logic signed [32:0] n_qs;
    logic signed [32:0] n_ang;
    logic signed [25:0] n_err;
    logic [24:0]        n_amag;
    logic signed [23:0] n_isum;
    logic signed [22:0] n_integ;
    logic signed [26:0] n_dlt;
    logic signed [63:0] n_lim, n_pid, n_pmag;
    logic [7:0]         n_level;

    always_comb begin
        n_xs = r_x >>> r_cnt;
        n_ys = r_y >>> r_cnt;
        n_x0 = $signed({{4{r_az[11]}}, r_az, 16'd0});
        n_y0 = $signed({{4{r_ay[11]}}, r_ay, 16'd0});
        if (r_z > DEG180_Q16) begin
            n_zc = DEG180_Q16;
        end else if (r_z < -DEG180_Q16) begin
            n_zc = -DEG180_Q16;
        end else begin
            n_zc = r_z;
        end
        n_gprod = $signed({{11{r_gy[15]}}, r_gy}) * 27'sd1792;
        n_gmag  = (n_gprod[26] ? DIV_W'(-n_gprod) : DIV_W'(n_gprod)) + DIV_W'(312);
        n_qs    = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        n_inc   = n_qs[26:0];
        n_s     = 28'(r_angle) + 28'(n_inc);
        n_num   = 36'(n_s) * 36'sd98 + 36'(r_tilt) * 36'sd2;
        n_nmag  = (n_num[35] ? DIV_W'(-n_num) : DIV_W'(n_num)) + DIV_W'(50);
        if (n_qs > 33'(DEG180_Q16)) begin
            n_ang = 33'(DEG180_Q16);
        end else if (n_qs < -33'(DEG180_Q16)) begin
            n_ang = -33'(DEG180_Q16);
        end else begin
            n_ang = n_qs;
        end
        n_err   = 26'(r_target) - 26'(r_angle);
        n_amag  = r_angle[24] ? 25'(-r_angle) : 25'(r_angle);
        n_isum  = 24'(r_integ) + 24'(n_qs);
        if (n_isum > INT_LIM_Q16) begin
            n_integ = 23'(INT_LIM_Q16);
        end else if (n_isum < -INT_LIM_Q16) begin
            n_integ = 23'(-INT_LIM_Q16);
        end else begin
            n_integ = n_isum[22:0];
        end
        n_dlt   = 27'(r_err) - 27'(r_last);
        n_lim   = $signed({24'd0, r_ceiling, 32'd0});
        if (r_acc > n_lim) begin
            n_pid = n_lim;
        end else if (r_acc < -n_lim) begin
            n_pid = -n_lim;
        end else begin
            n_pid = r_acc;
        end
        n_pmag  = n_pid[63] ? -n_pid : n_pid;
        n_level = (n_pmag[39:32] < r_floor) ? r_floor : n_pmag[39:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_P;
            r_angle     <= '0;
            r_integ     <= '0;
            r_last      <= '0;
            r_div_req   <= '{start: 1'b0, sel: DIV_GYRO};
            r_out_valid <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ay    <= i_accel_y_word[15:4];
                        r_az    <= i_accel_z_word[15:4];
                        r_gy    <= i_gyro_y_word;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_zero <= (r_ay == 12'sd0) && (r_az == 12'sd0);
                    r_cnt  <= '0;
                    // left half-plane: pre-rotate by 180 degrees
                    if (r_az[11]) begin
                        r_x <= -n_x0;
                        r_y <= -n_y0;
                        r_z <= r_ay[11] ? -DEG180_Q16 : DEG180_Q16;
                    end else begin
                        r_x <= n_x0;
                        r_y <= n_y0;
                        r_z <= '0;
                    end
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_y[31]) begin
                        r_x <= r_x + n_ys;
                        r_y <= r_y - n_xs;
                        r_z <= r_z + ATAN_DEG_Q16[r_cnt];
                    end else begin
                        r_x <= r_x - n_ys;
                        r_y <= r_y + n_xs;
                        r_z <= r_z - ATAN_DEG_Q16[r_cnt];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ATAN_CNT_W'(CORDIC_N - 1)) begin
                        r_state <= S_TILT;
                    end
                end
                S_TILT: begin
                    r_tilt    <= (r_zero ? 27'sd0 : n_zc) - 27'(r_offset);
                    r_neg     <= n_gprod[26];
                    r_div_arg <= n_gmag;
                    r_div_req <= '{start: 1'b1, sel: DIV_GYRO};
                    r_state   <= S_DIVG;
                end
                S_DIVG: begin
                    if (w_div_stat.done) begin
                        r_neg     <= n_num[35];
                        r_div_arg <= n_nmag;
                        r_div_req <= '{start: 1'b1, sel: DIV_ANGLE};
                        r_state   <= S_DIVA;
                    end
                end
                S_DIVA: begin
                    if (w_div_stat.done) begin
                        r_angle <= n_ang[24:0];
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err <= n_err;
                    if (n_amag > {1'b0, r_cutoff}) begin
                        r_trip  <= 1'b1;
                        r_integ <= '0;
                        r_last  <= n_err;
                        r_dir   <= DIR_BRAKE;
                        r_level <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_trip    <= 1'b0;
                        r_neg     <= n_err[25];
                        r_div_arg <= (n_err[25] ? DIV_W'(-n_err) : DIV_W'(n_err))
                                     + DIV_W'(100);
                        r_div_req <= '{start: 1'b1, sel: DIV_INTEG};
                        r_state   <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    if (w_div_stat.done) begin
                        r_integ <= n_integ;
                        r_d200  <= 35'(n_dlt) * 35'sd200;
                        r_last  <= r_err;
                        r_acc   <= '0;
                        r_mcand <= 64'(r_err);
                        r_mgain <= r_gain_p;
                        r_mcnt  <= '0;
                        r_phase <= PH_P;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mgain[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand <= r_mcand <<< 1;
                    r_mgain <= r_mgain >> 1;
                    r_mcnt  <= r_mcnt + 1'b1;
                    if (r_mcnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                        r_mcnt <= '0;
                        case (r_phase)
                            PH_P: begin
                                r_mcand <= 64'(r_integ);
                                r_mgain <= r_gain_i;
                                r_phase <= PH_I;
                            end
                            PH_I: begin
                                r_mcand <= 64'(r_d200);
                                r_mgain <= r_gain_d;
                                r_phase <= PH_D;
                            end
                            default: begin
                                r_state <= S_PID;
                            end
                        endcase
                    end
                end
                S_PID: begin
                    if (n_pid == 64'sd0) begin
                        r_dir   <= DIR_BRAKE;
                        r_level <= '0;
                    end else begin
                        r_dir   <= n_pid[63] ? DIR_BACK : DIR_FWD;
                        r_level <= n_level;
                    end
                    r_state <= S_DIVW;
                    r_div_req <= '{start: 1'b1, sel: DIV_PWM};
                    r_div_arg <= (n_pid == 64'sd0) ? '0
                                 : DIV_W'(n_level) * DIV_W'(PWM_MAX_COUNT);
                end
                S_DIVW: begin
                    if (w_div_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_dir     <= r_dir;
                        r_o_level   <= r_level;
                        r_o_pwm     <= r_trip ? 10'd0 : w_quot[9:0];
                        r_o_trip    <= r_trip;
                        r_o_angle   <= r_angle;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_motor_direction = r_o_dir;
    assign o_drive_level     = r_o_level;
    assign o_pwm_compare     = r_o_pwm;
    assign o_tilt_tripped    = r_o_trip;
    assign o_angle_estimate  = r_o_angle;

endmodule

// ===== rtl/core/tbp_checker.sv =====
// Port-level checks on the tilt balance controller, bound to the top level.
// Depends on tbp_pkg and tilt_balance_pid_controller_defines.svh.
`include "tilt_balance_pid_controller_defines.svh"

module tbp_checker
    import tbp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [2:0]         i_cfg_index,
    input logic [24:0]        i_cfg_data,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [15:0] i_accel_y_word,
    input logic signed [15:0] i_accel_z_word,
    input logic signed [15:0] i_gyro_y_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_motor_direction,
    input logic [7:0]         o_drive_level,
    input logic [9:0]         o_pwm_compare,
    input logic               o_tilt_tripped,
    input logic signed [24:0] o_angle_estimate
);

    `TBP_ASSERT_NOW(a_trip_brakes, o_out_valid && o_tilt_tripped, o_motor_direction == DIR_BRAKE && o_drive_level == 8'd0, "tripped item not braked")

    `TBP_ASSERT_NOW(a_brake_idle, o_out_valid && o_motor_direction == DIR_BRAKE, o_drive_level == 8'd0 && o_pwm_compare == 10'd0, "brake with drive")

    `TBP_ASSERT_NOW(a_pwm_level, o_out_valid, o_pwm_compare <= PWM_MAX_COUNT && ((o_drive_level == 8'd0) == (o_pwm_compare == 10'd0)), "pwm inconsistent with level")

    `TBP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_angle_estimate) && $stable(o_pwm_compare), "stalled item changed")

endmodule

bind tilt_balance_pid_controller tbp_checker u_tbp_checker (.*);
